@@ rtl/grid_free_neighbor_enumerator_defines.svh @@
// Assertion macros shared by the grid neighbour enumerator.
// They expand to nothing when SYNTHESIS is defined.
`ifndef GRID_FREE_NEIGHBOR_ENUMERATOR_DEFINES_SVH
`define GRID_FREE_NEIGHBOR_ENUMERATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define GFNE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gfne: same-cycle implication violated");
`define GFNE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gfne: next-cycle implication violated");
`else
`define GFNE_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define GFNE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/gfne_pkg.sv @@
package gfne_pkg;

   // Grid geometry.
   localparam int MAX_DIM    = 256;
   localparam int DIM_W      = 9;
   localparam int INDEX_W    = 16;
   localparam int CELLS_W    = 17;
   localparam int MAP_DEPTH  = MAX_DIM * MAX_DIM;
   localparam int MAP_ADDR_W = $clog2(MAP_DEPTH);
   localparam int REM_W      = $clog2(MAX_DIM);

   // Column remainder is built a few index bits per cycle.
   localparam int DIV_BITS   = 4;
   localparam int DIV_STEPS  = INDEX_W / DIV_BITS;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   // Work queue between the front and back parts; depth must be a power of two.
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Neighbour positions, in emission order.
   localparam int NEIGHBOURS = 8;
   localparam int NB_W       = 3;
   localparam logic [NB_W-1:0] NB_TOP_LEFT     = 3'd0;
   localparam logic [NB_W-1:0] NB_TOP          = 3'd1;
   localparam logic [NB_W-1:0] NB_TOP_RIGHT    = 3'd2;
   localparam logic [NB_W-1:0] NB_LEFT         = 3'd3;
   localparam logic [NB_W-1:0] NB_RIGHT        = 3'd4;
   localparam logic [NB_W-1:0] NB_BOTTOM_LEFT  = 3'd5;
   localparam logic [NB_W-1:0] NB_BOTTOM       = 3'd6;
   localparam logic [NB_W-1:0] NB_BOTTOM_RIGHT = 3'd7;

   // Transaction function codes.
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // Result status codes.
   localparam int STATUS_W = 2;
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BLOCKED = 2'd2;

   // Control register indexes.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_HEIGHT = 1'b1;

   // One classified transaction handed from the front to the back.
   typedef struct packed {
      logic                  func;
      logic [INDEX_W-1:0]    cell_index;
      logic                  cell_blocked;
      logic                  in_range;
      logic [NEIGHBOURS-1:0] ok_mask;
   } work_type;

   // One result transaction.
   typedef struct packed {
      logic [INDEX_W-1:0]  neighbor_index;
      logic                neighbor_valid;
      logic [STATUS_W-1:0] status;
      logic                last;
   } result_type;

   // A dimension of zero acts as one and anything above the maximum is clipped.
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end
      return r;
   endfunction

endpackage

@@ rtl/gfne_if.sv @@
// Request channel: one map write or one neighbour query per transaction.
interface gfne_req_if;
   logic                         valid;
   logic                         ready;
   logic                         func;
   logic [gfne_pkg::INDEX_W-1:0] cell_index;
   logic                         cell_blocked;

   modport source (output valid, output func, output cell_index, output cell_blocked,
                   input ready);
   modport sink (input valid, input func, input cell_index, input cell_blocked,
                 output ready);
endinterface

// Response channel: one neighbour or status result per transaction.
interface gfne_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [gfne_pkg::INDEX_W-1:0]  neighbor_index;
   logic                          neighbor_valid;
   logic [gfne_pkg::STATUS_W-1:0] status;
   logic                          last;

   modport source (output valid, output neighbor_index, output neighbor_valid,
                   output status, output last, input ready);
   modport sink (input valid, input neighbor_index, input neighbor_valid,
                 input status, input last, output ready);
endinterface

@@ rtl/gfne_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered data.
module gfne_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage has no reset; contents are undefined until written.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/gfne_front.sv @@
// Front part: accepts request transactions, works out the column of a
// queried cell and classifies the transaction before queueing it.
module gfne_front (
   input  logic                       clock,
   input  logic                       reset,
   gfne_req_if.sink                   req_ch,
   input  logic [gfne_pkg::DIM_W-1:0] grid_w,
   input  logic [gfne_pkg::DIM_W-1:0] grid_h,
   output logic                       push_valid,
   input  logic                       push_ready,
   output gfne_pkg::work_type         push_data
);

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_DIV  = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;

   logic [1:0]                       state_ff, state_in;
   logic                             func_ff, func_in;
   logic [gfne_pkg::INDEX_W-1:0]     idx_ff, idx_in;
   logic                             blk_ff, blk_in;
   logic [gfne_pkg::INDEX_W-1:0]     shift_ff, shift_in;
   logic [gfne_pkg::REM_W-1:0]       rem_ff, rem_in;
   logic [gfne_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [gfne_pkg::CELLS_W-1:0]     cells_ff, cells_in;
   logic [gfne_pkg::REM_W-1:0]       rem_div;
   logic                             up, down, lf, rt, in_range;

   // One restoring remainder step: bring in the next index bit and reduce.
   function automatic logic [gfne_pkg::REM_W-1:0] rem_step(
      input logic [gfne_pkg::REM_W-1:0] rem,
      input logic                       bit_in,
      input logic [gfne_pkg::DIM_W-1:0] w
   );
      logic [gfne_pkg::REM_W:0] t;
      t = {rem, bit_in};
      if (t >= (gfne_pkg::REM_W + 1)'(w)) begin
         t = t - (gfne_pkg::REM_W + 1)'(w);
      end
      return t[gfne_pkg::REM_W-1:0];
   endfunction

   // Several remainder steps per cycle, most significant index bits first.
   always_comb begin
      rem_div = rem_ff;
      for (int i = 0; i < gfne_pkg::DIV_BITS; i++) begin
         rem_div = rem_step(rem_div, shift_ff[gfne_pkg::INDEX_W-1-i], grid_w);
      end
   end

   // Cell count registered; registers must not change if busy; unenforced.
   assign cells_in = gfne_pkg::CELLS_W'(grid_w) * gfne_pkg::CELLS_W'(grid_h);

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      func_in  = func_ff;
      idx_in   = idx_ff;
      blk_in   = blk_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_ch.valid) begin
               func_in  = req_ch.func;
               idx_in   = req_ch.cell_index;
               blk_in   = req_ch.cell_blocked;
               shift_in = req_ch.cell_index;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = (req_ch.func == gfne_pkg::FUNC_QUERY) ? F_DIV : F_PUSH;
            end
         end
         F_DIV: begin
            shift_in = shift_ff << gfne_pkg::DIV_BITS;
            rem_in   = rem_div;
            cnt_in   = cnt_ff + gfne_pkg::DIV_CNT_W'(1);
            if (cnt_ff == gfne_pkg::DIV_CNT_W'(gfne_pkg::DIV_STEPS - 1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Transaction payload and arithmetic.
   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      idx_ff   <= idx_in;
      blk_ff   <= blk_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      cells_ff <= cells_in;
   end

   // Edge classification from the row bounds and the column remainder.
   assign in_range = gfne_pkg::CELLS_W'(idx_ff) < cells_ff;
   assign up       = idx_ff >= gfne_pkg::INDEX_W'(grid_w);
   assign down     = (gfne_pkg::CELLS_W'(idx_ff) + gfne_pkg::CELLS_W'(grid_w)) < cells_ff;
   assign lf       = rem_ff != '0;
   assign rt       = (gfne_pkg::DIM_W'(rem_ff) + gfne_pkg::DIM_W'(1)) < grid_w;

   always_comb begin
      push_data              = '0;
      push_data.func         = func_ff;
      push_data.cell_index   = idx_ff;
      push_data.cell_blocked = blk_ff;
      push_data.in_range     = in_range;
      push_data.ok_mask[gfne_pkg::NB_TOP_LEFT]     = up && lf;
      push_data.ok_mask[gfne_pkg::NB_TOP]          = up;
      push_data.ok_mask[gfne_pkg::NB_TOP_RIGHT]    = up && rt;
      push_data.ok_mask[gfne_pkg::NB_LEFT]         = lf;
      push_data.ok_mask[gfne_pkg::NB_RIGHT]        = rt;
      push_data.ok_mask[gfne_pkg::NB_BOTTOM_LEFT]  = down && lf;
      push_data.ok_mask[gfne_pkg::NB_BOTTOM]       = down;
      push_data.ok_mask[gfne_pkg::NB_BOTTOM_RIGHT] = down && rt;
   end

   assign push_valid   = state_ff == F_PUSH;
   assign req_ch.ready = state_ff == F_IDLE;

endmodule

@@ rtl/gfne_fifo.sv @@
`include "grid_free_neighbor_enumerator_defines.svh"

// Short work queue between the front and back parts.
module gfne_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  gfne_pkg::work_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output gfne_pkg::work_type pop_data
);

   gfne_pkg::work_type              entries_ff [gfne_pkg::FIFO_DEPTH];
   logic [gfne_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [gfne_pkg::FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [gfne_pkg::FIFO_CNT_W-1:0] count_ff, count_in;
   logic                            push_fire, pop_fire;

   assign push_ready = count_ff != gfne_pkg::FIFO_CNT_W'(gfne_pkg::FIFO_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // Pointers wrap naturally since the depth is a power of two.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = wr_ptr_ff + gfne_pkg::FIFO_PTR_W'(1);
      end
      if (pop_fire) begin
         rd_ptr_in = rd_ptr_ff + gfne_pkg::FIFO_PTR_W'(1);
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + gfne_pkg::FIFO_CNT_W'(1);
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - gfne_pkg::FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push_fire) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   `GFNE_ASSERT_IMPLY(a_fifo_bound, clock, reset, 1'b1, count_ff <= gfne_pkg::FIFO_CNT_W'(gfne_pkg::FIFO_DEPTH))
   `GFNE_ASSERT_NEXT(a_fifo_fill, clock, reset, push_fire && !pop_fire, count_ff != '0)

endmodule

@@ rtl/gfne_back.sv @@
`include "grid_free_neighbor_enumerator_defines.svh"

// Back part: owns the obstacle map, applies writes, reads the start cell and
// its eight neighbours and emits the results through an output register.
module gfne_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [gfne_pkg::DIM_W-1:0] grid_w,
   input  logic                       pop_valid,
   output logic                       pop_ready,
   input  gfne_pkg::work_type         pop_data,
   gfne_rsp_if.source                 rsp_ch
);

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_READ = 2'd1;
   localparam logic [1:0] B_EMIT = 2'd2;

   // Read slot zero is the start cell, slots one to eight the neighbours.
   localparam int SLOT_W = $clog2(gfne_pkg::NEIGHBOURS + 2);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(gfne_pkg::NEIGHBOURS);

   logic [1:0]                         state_ff, state_in;
   gfne_pkg::work_type                 work_ff, work_in;
   logic [SLOT_W-1:0]                  rd_cnt_ff, rd_cnt_in;
   logic                               pend_ff, pend_in;
   logic [SLOT_W-1:0]                  slot_ff, slot_in;
   logic [gfne_pkg::STATUS_W-1:0]      status_ff, status_in;
   logic [gfne_pkg::NEIGHBOURS-1:0]    free_ff, free_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   gfne_pkg::result_type               res_ff, res_in;

   logic                               pop_fire, issue, out_free;
   logic                               ram_wr_en;
   logic [gfne_pkg::MAP_ADDR_W-1:0]    ram_rd_addr;
   logic [0:0]                         ram_rd_data;
   logic [gfne_pkg::NB_W-1:0]          pick;
   logic [gfne_pkg::NEIGHBOURS-1:0]    rest_mask;

   // Linear index of one neighbour position.
   function automatic logic [gfne_pkg::INDEX_W-1:0] nb_addr(
      input logic [gfne_pkg::INDEX_W-1:0] idx,
      input logic [gfne_pkg::DIM_W-1:0]   w,
      input logic [gfne_pkg::NB_W-1:0]    k
   );
      logic [gfne_pkg::INDEX_W-1:0] wx;
      logic [gfne_pkg::INDEX_W-1:0] r;
      wx = gfne_pkg::INDEX_W'(w);
      case (k)
         gfne_pkg::NB_TOP_LEFT:     r = idx - wx - gfne_pkg::INDEX_W'(1);
         gfne_pkg::NB_TOP:          r = idx - wx;
         gfne_pkg::NB_TOP_RIGHT:    r = idx - wx + gfne_pkg::INDEX_W'(1);
         gfne_pkg::NB_LEFT:         r = idx - gfne_pkg::INDEX_W'(1);
         gfne_pkg::NB_RIGHT:        r = idx + gfne_pkg::INDEX_W'(1);
         gfne_pkg::NB_BOTTOM_LEFT:  r = idx + wx - gfne_pkg::INDEX_W'(1);
         gfne_pkg::NB_BOTTOM:       r = idx + wx;
         gfne_pkg::NB_BOTTOM_RIGHT: r = idx + wx + gfne_pkg::INDEX_W'(1);
         default:                   r = idx;
      endcase
      return r;
   endfunction

   // Obstacle map.
   gfne_ram #(
      .WIDTH (1),
      .DEPTH (gfne_pkg::MAP_DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (gfne_pkg::MAP_ADDR_W'(pop_data.cell_index)),
      .wr_data (pop_data.cell_blocked),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign pop_ready = state_ff == B_IDLE;
   assign pop_fire  = pop_valid && pop_ready;
   assign ram_wr_en = pop_fire && (pop_data.func == gfne_pkg::FUNC_WRITE) && pop_data.in_range;
   assign issue     = (state_ff == B_READ) && (rd_cnt_ff <= SLOT_LAST);
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;

   // Read address: the start cell first, then each neighbour in order.
   always_comb begin
      if (rd_cnt_ff == '0) begin
         ram_rd_addr = gfne_pkg::MAP_ADDR_W'(work_ff.cell_index);
      end else begin
         ram_rd_addr = gfne_pkg::MAP_ADDR_W'(nb_addr(work_ff.cell_index, grid_w,
                                              gfne_pkg::NB_W'(rd_cnt_ff - SLOT_W'(1))));
      end
   end

   // Lowest free neighbour still to be emitted.
   always_comb begin
      pick = '0;
      for (int i = gfne_pkg::NEIGHBOURS - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            pick = gfne_pkg::NB_W'(i);
         end
      end
      rest_mask = free_ff & ~(gfne_pkg::NEIGHBOURS'(1) << pick);
   end

   // Next-state logic of the sequencer and output register.
   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      rd_cnt_in    = rd_cnt_ff;
      pend_in      = issue;
      slot_in      = rd_cnt_ff;
      status_in    = status_ff;
      free_in      = free_ff;
      rsp_valid_in = rsp_valid_ff;
      res_in       = res_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         B_IDLE: begin
            if (pop_valid && pop_data.func == gfne_pkg::FUNC_QUERY) begin
               work_in   = pop_data;
               free_in   = '0;
               rd_cnt_in = '0;
               if (pop_data.in_range) begin
                  status_in = gfne_pkg::STATUS_OK;
                  state_in  = B_READ;
               end else begin
                  status_in = gfne_pkg::STATUS_RANGE;
                  state_in  = B_EMIT;
               end
            end
         end
         B_READ: begin
            if (issue) begin
               rd_cnt_in = rd_cnt_ff + SLOT_W'(1);
            end
            if (pend_ff) begin
               if (slot_ff == '0) begin
                  if (ram_rd_data[0]) begin
                     status_in = gfne_pkg::STATUS_BLOCKED;
                  end
               end else begin
                  free_in[gfne_pkg::NB_W'(slot_ff - SLOT_W'(1))] =
                     work_ff.ok_mask[gfne_pkg::NB_W'(slot_ff - SLOT_W'(1))] && !ram_rd_data[0];
               end
               if (slot_ff == SLOT_LAST) begin
                  state_in = B_EMIT;
               end
            end
         end
         B_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (status_ff != gfne_pkg::STATUS_OK || free_ff == '0) begin
                  // Single status result: range error, blocked start or no free neighbour.
                  res_in.neighbor_index = '0;
                  res_in.neighbor_valid = 1'b0;
                  res_in.status         = status_ff;
                  res_in.last           = 1'b1;
                  state_in              = B_IDLE;
               end else begin
                  res_in.neighbor_index = nb_addr(work_ff.cell_index, grid_w, pick);
                  res_in.neighbor_valid = 1'b1;
                  res_in.status         = gfne_pkg::STATUS_OK;
                  res_in.last           = rest_mask == '0;
                  free_in               = rest_mask;
                  if (rest_mask == '0) begin
                     state_in = B_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      work_ff   <= work_in;
      rd_cnt_ff <= rd_cnt_in;
      slot_ff   <= slot_in;
      status_ff <= status_in;
      free_ff   <= free_in;
      res_ff    <= res_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.neighbor_index = res_ff.neighbor_index;
   assign rsp_ch.neighbor_valid = res_ff.neighbor_valid;
   assign rsp_ch.status         = res_ff.status;
   assign rsp_ch.last           = res_ff.last;

   `GFNE_ASSERT_IMPLY(a_err_single, clock, reset, rsp_valid_ff && res_ff.status != gfne_pkg::STATUS_OK, res_ff.last && !res_ff.neighbor_valid)
   `GFNE_ASSERT_IMPLY(a_nb_ok, clock, reset, rsp_valid_ff && res_ff.neighbor_valid, res_ff.status == gfne_pkg::STATUS_OK)

endmodule

@@ rtl/grid_free_neighbor_enumerator.sv @@
// The front sends a write from idle to push; a query runs the division steps in between.
// For an in-range query the back makes nine reads of the map through its one read port,
// then emits at least one result, up to one per cycle while its output register is free;
// it takes no new work until then, and this sets the sustained query rate.
// Synchronous active-high reset clears control state and sets both dimensions to 256;
// the obstacle map is not cleared and holds undefined data until written.
module grid_free_neighbor_enumerator (
   input  logic                             clock,
   input  logic                             reset,
   gfne_req_if.sink                         req_ch,
   gfne_rsp_if.source                       rsp_ch,
   input  logic                             csr_wr_en,
   input  logic [gfne_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gfne_pkg::DIM_W-1:0]       csr_wr_data
);

   logic [gfne_pkg::DIM_W-1:0] grid_width_ff, grid_width_in;
   logic [gfne_pkg::DIM_W-1:0] grid_height_ff, grid_height_in;
   logic [gfne_pkg::DIM_W-1:0] grid_w, grid_h;
   logic                       push_valid, push_ready, pop_valid, pop_ready;
   gfne_pkg::work_type         push_data, pop_data;

   // Control register writes.
   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_wr_en) begin
         case (csr_index)
            gfne_pkg::CSR_GRID_WIDTH:  grid_width_in  = csr_wr_data;
            gfne_pkg::CSR_GRID_HEIGHT: grid_height_in = csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= gfne_pkg::DIM_W'(gfne_pkg::MAX_DIM);
         grid_height_ff <= gfne_pkg::DIM_W'(gfne_pkg::MAX_DIM);
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
      end
   end

   // Effective dimensions after clamping.
   assign grid_w = gfne_pkg::eff_dim(grid_width_ff);
   assign grid_h = gfne_pkg::eff_dim(grid_height_ff);

   gfne_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .grid_w     (grid_w),
      .grid_h     (grid_h),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   gfne_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   gfne_back u_back (
      .clock     (clock),
      .reset     (reset),
      .grid_w    (grid_w),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_ch    (rsp_ch)
   );

endmodule

@@ tb/grid_free_neighbor_enumerator_tb.sv @@
`timescale 1ns / 1ps

module grid_free_neighbor_enumerator_tb;

   localparam int CLOCK_PERIOD    = 10;
   localparam int CYCLE_LIMIT     = 500000;
   localparam int SETTLE_CYCLES   = 40;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASE_QUOTA     = 66;
   localparam int MAX_REPORTS     = 40;

   typedef enum logic {STEP_ITEM, STEP_GRID} step_kind_type;

   // One row of the directed stimulus: either a transaction or a new grid shape.
   typedef struct {
      step_kind_type                 kind;
      logic                          func;
      logic [gfne_pkg::INDEX_W-1:0]  cell_index;
      logic                          cell_blocked;
      bit                            typed;
      logic [gfne_pkg::STATUS_W-1:0] typed_status;
      logic [gfne_pkg::DIM_W-1:0]    width_reg;
      logic [gfne_pkg::DIM_W-1:0]    height_reg;
   } directed_step_type;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             csr_wr_en;
   logic [gfne_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [gfne_pkg::DIM_W-1:0]       csr_wr_data;

   gfne_req_if req_ch ();
   gfne_rsp_if rsp_ch ();

   // Shadow of the block: obstacle map and effective grid shape.
   bit shadow_blocked [gfne_pkg::MAP_DEPTH];
   bit cell_written [gfne_pkg::MAP_DEPTH];
   int grid_w;
   int grid_h;
   int grid_cells;

   gfne_pkg::result_type expected_neighbours[$];
   directed_step_type    directed_rows[$];

   int burst_left;
   int mismatch_count;
   int results_checked;
   int queries_sent;
   int writes_sent;
   int grid_settings;
   int hold_offs_done;
   int cycle_count;
   bit hold_off_request;

   grid_free_neighbor_enumerator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // A register value of zero acts as one; anything above the maximum is clipped.
   function automatic int effective_dim(input logic [gfne_pkg::DIM_W-1:0] raw);
      if (raw == '0) begin
         return 1;
      end
      if (raw > gfne_pkg::MAX_DIM) begin
         return gfne_pkg::MAX_DIM;
      end
      return int'(raw);
   endfunction

   function automatic gfne_pkg::result_type make_result(
      input int                            nidx,
      input logic                          nvalid,
      input logic [gfne_pkg::STATUS_W-1:0] stat,
      input logic                          fin
   );
      gfne_pkg::result_type r;
      r.neighbor_index = gfne_pkg::INDEX_W'(nidx);
      r.neighbor_valid = nvalid;
      r.status         = stat;
      r.last           = fin;
      return r;
   endfunction

   // Appends one expected result transaction at the tail of the queue.
   function automatic void expect_result(input gfne_pkg::result_type r);
      expected_neighbours = {expected_neighbours, r};
   endfunction

   // Applies one accepted transaction to the shadow map and queues its results.
   task automatic predict_neighbours(input logic func,
                                     input logic [gfne_pkg::INDEX_W-1:0] idx,
                                     input logic blk);
      int                   centre;
      int                   row;
      int                   col;
      int                   dr;
      int                   dc;
      int                   nb;
      gfne_pkg::result_type found_list[$];
      centre = int'(idx);
      if (func == gfne_pkg::FUNC_WRITE) begin
         if (centre < grid_cells) begin
            shadow_blocked[centre] = blk;
         end
      end else if (centre >= grid_cells) begin
         expect_result(make_result(0, 1'b0, gfne_pkg::STATUS_RANGE, 1'b1));
      end else if (shadow_blocked[centre]) begin
         expect_result(make_result(0, 1'b0, gfne_pkg::STATUS_BLOCKED, 1'b1));
      end else begin
         row = centre / grid_w;
         col = centre % grid_w;
         // Scanning the 3x3 window row by row gives the required emission order.
         for (dr = -1; dr <= 1; dr++) begin
            for (dc = -1; dc <= 1; dc++) begin
               if ((dr != 0 || dc != 0) && row + dr >= 0 && row + dr < grid_h &&
                   col + dc >= 0 && col + dc < grid_w) begin
                  nb = centre + dr * grid_w + dc;
                  if (!shadow_blocked[nb]) begin
                     found_list = {found_list,
                                   make_result(nb, 1'b1, gfne_pkg::STATUS_OK, 1'b0)};
                  end
               end
            end
         end
         if (found_list.size() == 0) begin
            expect_result(make_result(0, 1'b0, gfne_pkg::STATUS_OK, 1'b1));
         end else begin
            found_list[found_list.size() - 1].last = 1'b1;
            foreach (found_list[i]) begin
               expect_result(found_list[i]);
            end
         end
      end
   endtask

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%0t: mismatch: %s", $time, what);
      end
   endtask

   // Offers one request transaction, in bursts separated by random gaps.
   // Called and returning at a falling edge.
   task automatic send_item(input logic func, input logic [gfne_pkg::INDEX_W-1:0] idx,
                            input logic blk, input bit typed,
                            input logic [gfne_pkg::STATUS_W-1:0] typed_status);
      int gap_len;
      if (burst_left == 0) begin
         gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap_len != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap_len) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      if (func == gfne_pkg::FUNC_WRITE && int'(idx) < grid_cells) begin
         cell_written[idx] = 1'b1;
      end
      req_ch.valid        <= 1'b1;
      req_ch.func         <= func;
      req_ch.cell_index   <= idx;
      req_ch.cell_blocked <= blk;
      do @(posedge clock); while (!req_ch.ready);
      if (typed) begin
         expect_result(make_result(0, 1'b0, typed_status, 1'b1));
      end else begin
         predict_neighbours(func, idx, blk);
      end
      if (func == gfne_pkg::FUNC_QUERY) begin
         queries_sent++;
      end else begin
         writes_sent++;
      end
      @(negedge clock);
   endtask

   // Changes the grid shape once the block has gone quiet.
   task automatic set_grid(input logic [gfne_pkg::DIM_W-1:0] width_raw,
                           input logic [gfne_pkg::DIM_W-1:0] height_raw);
      req_ch.valid <= 1'b0;
      while (expected_neighbours.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= gfne_pkg::CSR_GRID_WIDTH;
      csr_wr_data <= width_raw;
      @(negedge clock);
      csr_index   <= gfne_pkg::CSR_GRID_HEIGHT;
      csr_wr_data <= height_raw;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      grid_w      = effective_dim(width_raw);
      grid_h      = effective_dim(height_raw);
      grid_cells  = grid_w * grid_h;
      burst_left  = 0;
      grid_settings++;
   endtask

   // Leans towards the edges and a small corner window so neighbourhoods get reused.
   function automatic int pick_coordinate(input int extent);
      case ($urandom_range(0, 3))
         0: return 0;
         1: return extent - 1;
         2: return $urandom_range(0, extent - 1) % 6;
         default: return $urandom_range(0, extent - 1);
      endcase
   endfunction

   task automatic run_random_phase(input int quota);
      int counted;
      int choice;
      int centre;
      int row;
      int col;
      int dr;
      int dc;
      int nb;
      int block_odds;
      logic nb_blocked;
      logic [gfne_pkg::INDEX_W-1:0] idx;
      counted = 0;
      while (counted < quota) begin
         choice = $urandom_range(0, 9);
         if (choice < 8) begin
            // Write every unknown cell of a neighbourhood, refresh a few, then query it.
            row        = pick_coordinate(grid_h);
            col        = pick_coordinate(grid_w);
            centre     = row * grid_w + col;
            block_odds = $urandom_range(0, 7);
            for (dr = -1; dr <= 1; dr++) begin
               for (dc = -1; dc <= 1; dc++) begin
                  if (row + dr >= 0 && row + dr < grid_h &&
                      col + dc >= 0 && col + dc < grid_w) begin
                     nb = centre + dr * grid_w + dc;
                     if (!cell_written[nb] || $urandom_range(0, 3) == 0) begin
                        if (nb == centre) begin
                           nb_blocked = ($urandom_range(0, 4) == 0);
                        end else begin
                           nb_blocked = ($urandom_range(0, 7) < block_odds);
                        end
                        send_item(gfne_pkg::FUNC_WRITE, gfne_pkg::INDEX_W'(nb), nb_blocked,
                                  1'b0, gfne_pkg::STATUS_OK);
                        counted++;
                     end
                  end
               end
            end
            send_item(gfne_pkg::FUNC_QUERY, gfne_pkg::INDEX_W'(centre),
                      1'($urandom_range(0, 1)), 1'b0, gfne_pkg::STATUS_OK);
            counted++;
         end else if (choice == 8 && grid_cells < gfne_pkg::MAP_DEPTH) begin
            // Beyond the last cell: a query reports a range error, a write is dropped.
            idx = gfne_pkg::INDEX_W'($urandom_range(grid_cells, gfne_pkg::MAP_DEPTH - 1));
            if ($urandom_range(0, 1) == 1) begin
               send_item(gfne_pkg::FUNC_QUERY, idx, 1'($urandom_range(0, 1)), 1'b0,
                         gfne_pkg::STATUS_OK);
               counted++;
            end else begin
               send_item(gfne_pkg::FUNC_WRITE, idx, 1'($urandom_range(0, 1)), 1'b0,
                         gfne_pkg::STATUS_OK);
            end
         end else begin
            // A stray write anywhere on the grid.
            idx = gfne_pkg::INDEX_W'($urandom_range(0, grid_cells - 1));
            send_item(gfne_pkg::FUNC_WRITE, idx, 1'($urandom_range(0, 1)), 1'b0,
                      gfne_pkg::STATUS_OK);
            counted++;
         end
      end
   endtask

   function automatic void row_item(input logic func, input int idx, input logic blk);
      directed_step_type s;
      s.kind         = STEP_ITEM;
      s.func         = func;
      s.cell_index   = gfne_pkg::INDEX_W'(idx);
      s.cell_blocked = blk;
      s.typed        = 1'b0;
      s.typed_status = gfne_pkg::STATUS_OK;
      s.width_reg    = '0;
      s.height_reg   = '0;
      directed_rows  = {directed_rows, s};
   endfunction

   // A query whose single result is known in advance.
   function automatic void row_known_query(input int idx,
                                           input logic [gfne_pkg::STATUS_W-1:0] stat);
      directed_step_type s;
      s.kind         = STEP_ITEM;
      s.func         = gfne_pkg::FUNC_QUERY;
      s.cell_index   = gfne_pkg::INDEX_W'(idx);
      s.cell_blocked = 1'b0;
      s.typed        = 1'b1;
      s.typed_status = stat;
      s.width_reg    = '0;
      s.height_reg   = '0;
      directed_rows  = {directed_rows, s};
   endfunction

   function automatic void row_grid(input int width_raw, input int height_raw);
      directed_step_type s;
      s.kind         = STEP_GRID;
      s.func         = gfne_pkg::FUNC_WRITE;
      s.cell_index   = '0;
      s.cell_blocked = 1'b0;
      s.typed        = 1'b0;
      s.typed_status = gfne_pkg::STATUS_OK;
      s.width_reg    = gfne_pkg::DIM_W'(width_raw);
      s.height_reg   = gfne_pkg::DIM_W'(height_raw);
      directed_rows  = {directed_rows, s};
   endfunction

   // Result transactions are compared in order against the shadow's expectations.
   always @(posedge clock) begin : result_check
      gfne_pkg::result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_neighbours.size() == 0) begin
            report_mismatch($sformatf("unexpected result index %0d valid %0b status %0d last %0b",
                                      rsp_ch.neighbor_index, rsp_ch.neighbor_valid,
                                      rsp_ch.status, rsp_ch.last));
         end else begin
            want = expected_neighbours.pop_front();
            if (rsp_ch.neighbor_index !== want.neighbor_index) begin
               report_mismatch($sformatf("neighbor_index %0d, wanted %0d",
                                         rsp_ch.neighbor_index, want.neighbor_index));
            end
            if (rsp_ch.neighbor_valid !== want.neighbor_valid) begin
               report_mismatch($sformatf("neighbor_valid %0b, wanted %0b",
                                         rsp_ch.neighbor_valid, want.neighbor_valid));
            end
            if (rsp_ch.status !== want.status) begin
               report_mismatch($sformatf("status %0d, wanted %0d", rsp_ch.status, want.status));
            end
            if (rsp_ch.last !== want.last) begin
               report_mismatch($sformatf("last %0b, wanted %0b", rsp_ch.last, want.last));
            end
            results_checked++;
         end
      end
   end

   // The receiver stalls on a rolling 16-bit pattern, with one long hold-off on request.
   // Bit 0 of every pattern is set, so an ordinary stall never runs past the end of its pattern.
   initial begin : result_sink
      int          hold_left;
      int          slot;
      logic [15:0] stall_pattern;
      hold_left     = 0;
      slot          = 0;
      stall_pattern = '1;
      forever begin
         @(negedge clock);
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left        = HOLD_OFF_CYCLES - 1;
            hold_offs_done++;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (slot == 0) begin
               stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                           : (16'($urandom()) | 16'h0001);
            end
            rsp_ch.ready <= stall_pattern[slot];
            slot = (slot + 1) % 16;
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, expected_neighbours.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_index           = gfne_pkg::CSR_GRID_WIDTH;
      csr_wr_data         = '0;
      req_ch.valid        = 1'b0;
      req_ch.func         = gfne_pkg::FUNC_WRITE;
      req_ch.cell_index   = '0;
      req_ch.cell_blocked = 1'b0;
      rsp_ch.ready        = 1'b0;
      hold_off_request    = 1'b0;
      burst_left          = 0;
      mismatch_count      = 0;
      results_checked     = 0;
      queries_sent        = 0;
      writes_sent         = 0;
      hold_offs_done      = 0;
      cycle_count         = 0;
      grid_settings       = 1;
      grid_w              = gfne_pkg::MAX_DIM;
      grid_h              = gfne_pkg::MAX_DIM;
      grid_cells          = gfne_pkg::MAX_DIM * gfne_pkg::MAX_DIM;

      // Top-left corner of the full grid, with a blocked diagonal neighbour.
      row_item(gfne_pkg::FUNC_WRITE, 0, 1'b0);
      row_item(gfne_pkg::FUNC_WRITE, 1, 1'b0);
      row_item(gfne_pkg::FUNC_WRITE, 256, 1'b0);
      row_item(gfne_pkg::FUNC_WRITE, 257, 1'b1);
      row_item(gfne_pkg::FUNC_QUERY, 0, 1'b1);
      // Highest index: blocked at first, then free with one blocked neighbour.
      row_item(gfne_pkg::FUNC_WRITE, 65535, 1'b1);
      row_known_query(65535, gfne_pkg::STATUS_BLOCKED);
      row_item(gfne_pkg::FUNC_WRITE, 65535, 1'b0);
      row_item(gfne_pkg::FUNC_WRITE, 65534, 1'b0);
      row_item(gfne_pkg::FUNC_WRITE, 65278, 1'b1);
      row_item(gfne_pkg::FUNC_WRITE, 65279, 1'b0);
      row_item(gfne_pkg::FUNC_QUERY, 65535, 1'b0);
      // Zero in both registers leaves a single cell, which has no neighbours.
      row_grid(0, 0);
      row_known_query(1, gfne_pkg::STATUS_RANGE);
      row_known_query(65535, gfne_pkg::STATUS_RANGE);
      row_known_query(0, gfne_pkg::STATUS_OK);
      row_item(gfne_pkg::FUNC_WRITE, 65535, 1'b1);
      // Values above the maximum clip back to the full grid; the dropped write must not show.
      row_grid(511, 300);
      row_item(gfne_pkg::FUNC_QUERY, 65535, 1'b0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == STEP_GRID) begin
            set_grid(directed_rows[i].width_reg, directed_rows[i].height_reg);
         end else begin
            send_item(directed_rows[i].func, directed_rows[i].cell_index,
                      directed_rows[i].cell_blocked, directed_rows[i].typed,
                      directed_rows[i].typed_status);
         end
      end

      // The long hold-off lands while the full grid is busy with queries.
      hold_off_request = 1'b1;
      run_random_phase(PHASE_QUOTA);
      set_grid(gfne_pkg::DIM_W'(1), gfne_pkg::DIM_W'(256));
      run_random_phase(PHASE_QUOTA);
      set_grid(gfne_pkg::DIM_W'(256), gfne_pkg::DIM_W'(1));
      run_random_phase(PHASE_QUOTA);
      set_grid(gfne_pkg::DIM_W'(3), gfne_pkg::DIM_W'(3));
      run_random_phase(PHASE_QUOTA);
      set_grid(gfne_pkg::DIM_W'(17), gfne_pkg::DIM_W'(256));
      run_random_phase(PHASE_QUOTA);
      set_grid(gfne_pkg::DIM_W'($urandom_range(2, 24)),
               gfne_pkg::DIM_W'($urandom_range(2, 24)));
      run_random_phase(PHASE_QUOTA);
      set_grid(gfne_pkg::DIM_W'($urandom_range(0, 511)),
               gfne_pkg::DIM_W'($urandom_range(0, 511)));
      run_random_phase(PHASE_QUOTA);

      req_ch.valid <= 1'b0;
      while (expected_neighbours.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d queries and %0d map writes over %0d grid shapes, %0d results checked.",
               queries_sent, writes_sent, grid_settings, results_checked);
      $display("Receiver held off %0d time(s) for %0d cycles; %0d mismatches seen.",
               hold_offs_done, HOLD_OFF_CYCLES, mismatch_count);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
